[hw/rtl/llns_pkg.sv]
package llns_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NODE_COUNT    = 1024;
    localparam int COUNT_BITS    = 16;

    localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int NODE_W  = 10;
    localparam int SOCK_W  = 3;
    localparam int CNODE_W = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CNODE_W-1:0]    NODE_NONE = CNODE_W'(NODE_COUNT);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_SELECT  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_SELECT  = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [NODE_W-1:0] node_id;
        logic [SOCK_W-1:0] node_socket;
        logic [SOCK_W-1:0] preferred_socket;
    } llns_req_t;

    typedef struct packed {
        logic               found;
        logic [CNODE_W-1:0] chosen_node;
        logic [SLOT_W-1:0]  chosen_slot;
        logic               was_local;
    } llns_rsp_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [NODE_W-1:0] node_id;
        logic [SOCK_W-1:0] node_socket;
        logic [SOCK_W-1:0] preferred_socket;
    } llns_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } llns_qstat_t;

endpackage

[hw/rtl/llns_front.sv]
module llns_front
    import llns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  llns_req_t   req,
    input  llns_qstat_t qstat,
    output logic        push,
    output llns_op_t    push_op
);

    logic     stage_valid_reg;
    logic     stage_valid_next;
    llns_op_t stage_op_reg;
    llns_op_t stage_op_next;
    logic     accept;

    assign busy   = stage_valid_reg && qstat.full;
    assign accept = start && !busy;
    assign push   = stage_valid_reg && !qstat.full;
    assign push_op = stage_op_reg;

    always_comb
    begin
        stage_op_next                  = stage_op_reg;
        stage_op_next.slot             = req.slot;
        stage_op_next.entry_valid      = req.entry_valid;
        stage_op_next.node_id          = req.node_id;
        stage_op_next.node_socket      = req.node_socket;
        stage_op_next.preferred_socket = req.preferred_socket;
        unique case (req.cmd)
            CMD_LOAD:    stage_op_next.op = OP_LOAD;
            CMD_SELECT:  stage_op_next.op = OP_SELECT;
            CMD_RELEASE: stage_op_next.op = OP_RELEASE;
            default:     stage_op_next.op = OP_NOP;
        endcase
        if (!accept)
        begin
            stage_op_next = stage_op_reg;
        end
        stage_valid_next = accept || (stage_valid_reg && qstat.full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_op_reg <= stage_op_next;
    end

endmodule

[hw/rtl/llns_queue.sv]
module llns_queue
    import llns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  llns_op_t    push_op,
    input  logic        pop,
    output llns_op_t    pop_op,
    output llns_qstat_t qstat
);

    llns_op_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_op      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hw/rtl/llns_back.sv]
module llns_back
    import llns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  llns_qstat_t qstat,
    input  llns_op_t    pop_op,
    output logic        pop,
    output logic        done,
    output llns_rsp_t   rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    llns_op_t              cur_reg;
    llns_op_t              cur_next;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     idx_next;

    logic                  valid_reg [TABLE_ENTRIES];
    logic [NODE_W-1:0]     node_reg  [TABLE_ENTRIES];
    logic [SOCK_W-1:0]     sock_reg  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] cnt_reg   [TABLE_ENTRIES];

    // best so far: on the preferred socket, and over all sockets
    logic                  loc_found_reg;
    logic                  loc_found_next;
    logic [SLOT_W-1:0]     loc_idx_reg;
    logic [SLOT_W-1:0]     loc_idx_next;
    logic [COUNT_BITS-1:0] loc_cnt_reg;
    logic [COUNT_BITS-1:0] loc_cnt_next;
    logic                  any_found_reg;
    logic                  any_found_next;
    logic [SLOT_W-1:0]     any_idx_reg;
    logic [SLOT_W-1:0]     any_idx_next;
    logic [COUNT_BITS-1:0] any_cnt_reg;
    logic [COUNT_BITS-1:0] any_cnt_next;

    logic                  done_reg;
    logic                  done_next;
    llns_rsp_t             rsp_reg;
    llns_rsp_t             rsp_next;

    logic                  eligible;
    logic                  is_local;
    logic [SLOT_W-1:0]     pick_idx;
    logic                  pick_found;

    logic                  wr_load;
    logic                  wr_dec;
    logic                  wr_inc;

    assign done = done_reg;
    assign rsp  = rsp_reg;
    assign pop  = (state_reg == S_IDLE) && !qstat.empty;

    assign eligible   = valid_reg[idx_reg] &&
                        ({1'b0, node_reg[idx_reg]} < NODE_NONE);
    assign is_local   = (sock_reg[idx_reg] == cur_reg.preferred_socket);
    assign pick_found = loc_found_reg || any_found_reg;
    assign pick_idx   = loc_found_reg ? loc_idx_reg : any_idx_reg;

    assign wr_load = (state_reg == S_EXEC) && (cur_reg.op == OP_LOAD);
    assign wr_dec  = (state_reg == S_EXEC) && (cur_reg.op == OP_RELEASE) &&
                     valid_reg[cur_reg.slot] && (cnt_reg[cur_reg.slot] != '0);
    assign wr_inc  = (state_reg == S_PICK) && pick_found &&
                     (cnt_reg[pick_idx] != COUNT_MAX);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        loc_found_next = loc_found_reg;
        loc_idx_next   = loc_idx_reg;
        loc_cnt_next   = loc_cnt_reg;
        any_found_next = any_found_reg;
        any_idx_next   = any_idx_reg;
        any_cnt_next   = any_cnt_reg;
        done_next      = 1'b0;
        rsp_next             = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    cur_next       = pop_op;
                    idx_next       = '0;
                    loc_found_next = 1'b0;
                    any_found_next = 1'b0;
                    state_next     = (pop_op.op == OP_SELECT) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN:
            begin
                if (eligible && is_local &&
                    (!loc_found_reg || cnt_reg[idx_reg] < loc_cnt_reg))
                begin
                    loc_found_next = 1'b1;
                    loc_idx_next   = idx_reg;
                    loc_cnt_next   = cnt_reg[idx_reg];
                end
                if (eligible && (!any_found_reg || cnt_reg[idx_reg] < any_cnt_reg))
                begin
                    any_found_next = 1'b1;
                    any_idx_next   = idx_reg;
                    any_cnt_next   = cnt_reg[idx_reg];
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                done_next            = 1'b1;
                rsp_next.found       = pick_found;
                rsp_next.chosen_node = pick_found ? {1'b0, node_reg[pick_idx]} : NODE_NONE;
                rsp_next.chosen_slot = pick_found ? pick_idx : '0;
                rsp_next.was_local   = loc_found_reg;
                state_next           = S_IDLE;
            end
            S_EXEC:
            begin
                done_next            = 1'b1;
                rsp_next.found       = 1'b0;
                rsp_next.chosen_node = NODE_NONE;
                rsp_next.chosen_slot = '0;
                rsp_next.was_local   = 1'b0;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                node_reg[i]  <= '0;
                sock_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_load)
            begin
                valid_reg[cur_reg.slot] <= cur_reg.entry_valid;
                node_reg[cur_reg.slot]  <= cur_reg.node_id;
                sock_reg[cur_reg.slot]  <= cur_reg.node_socket;
                cnt_reg[cur_reg.slot]   <= '0;
            end
            if (wr_dec)
            begin
                cnt_reg[cur_reg.slot] <= cnt_reg[cur_reg.slot] - 1'b1;
            end
            if (wr_inc)
            begin
                cnt_reg[pick_idx] <= cnt_reg[pick_idx] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        loc_found_reg <= loc_found_next;
        loc_idx_reg   <= loc_idx_next;
        loc_cnt_reg   <= loc_cnt_next;
        any_found_reg <= any_found_next;
        any_idx_reg   <= any_idx_next;
        any_cnt_reg   <= any_cnt_next;
        rsp_reg       <= rsp_next;
    end

endmodule

[hw/rtl/least_loaded_local_node_select.sv]
// Least-loaded worker selection with socket preference. An item is taken when
// start is high and busy is low; every item gives exactly one result, shown
// for one cycle with done high, and the result cannot be held off. Items pass
// a one-item input stage and a two-item queue, so busy rises only when both
// are full. A load, release or unused command goes from idle to the exec
// state of the table logic, which registers its result; a select walks the
// 16-entry table one entry per cycle, tracking the best local and best overall
// entry in the same sweep, then registers its result in the pick state. The
// table logic pops the next item from the queue only once it is back in idle.
module least_loaded_local_node_select
    import llns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  llns_req_t req,
    output logic      done,
    output llns_rsp_t rsp
);

    llns_qstat_t qstat;
    logic        push;
    llns_op_t    push_op;
    logic        pop;
    llns_op_t    pop_op;

    llns_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .qstat   (qstat),
        .push    (push),
        .push_op (push_op)
    );

    llns_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .qstat   (qstat)
    );

    llns_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .pop_op (pop_op),
        .pop    (pop),
        .done   (done),
        .rsp    (rsp)
    );

endmodule
